/* design/sha256_stream_hasher_assert.svh */
// ----------------------------------------------------------------------------
// sha256_stream_hasher_assert
// Assertion macros used by the sha_engine module.
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_ASSERT_SVH
`define SHA256_STREAM_HASHER_ASSERT_SVH

// Check that a condition implies another at the same edge.
`define SHA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another at the next edge.
`define SHA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/sha_pkg.sv */
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions of the SHA-256 hasher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sha_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [31:0] PAD_WORD  = 32'h8000_0000;
  localparam logic [7:0]  PAD_BYTE  = 8'h80;
  localparam logic [3:0]  LEN_WORD  = 4'd14;

  // Word kinds passed from front to back.
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_FINAL = 2'd1
  } kind_t;

  // One word sent to the block engine: message data or a final trigger.
  typedef struct packed {
    kind_t       kind;
    logic [31:0] data;
    logic [63:0] bit_len;
  } qword_t;

  typedef enum logic [2:0] {
    ST_LOAD   = 3'd0,
    ST_ROUND  = 3'd1,
    ST_ADD    = 3'd2,
    ST_PAD    = 3'd3,
    ST_EMIT   = 3'd4
  } bst_t;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
    return k[t];
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h [8];
    h = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
          32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
    return h[i];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

/* design/sha_front.sv */
// ----------------------------------------------------------------------------
// sha_front
// Accepts message words, masks and pads the last one, counts message length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha_front (
  input  logic           clk,
  input  logic           rst,
  input  logic [31:0]    data_word,
  input  logic [2:0]     valid_bytes,
  input  logic           last_word,
  input  logic           push,
  output logic           full,
  output sha_pkg::qword_t q_word,
  output logic           q_push,
  input  logic           q_full
);
  import sha_pkg::*;

  // Pending extra pad word after a full last word.
  logic        pad_pend;
  logic        pad_pend_next;
  logic [60:0] msg_bytes;
  logic [60:0] msg_bytes_next;
  logic [2:0]  nb;
  logic [31:0] keep;
  logic [31:0] padded;
  logic        take;

  assign full = q_full || pad_pend;
  assign take = push && !full;
  assign nb   = (valid_bytes > 3'd4) ? 3'd4 : valid_bytes;

  // Build the queued word for each kind of input.
  always_comb begin
    keep = '1;
    padded = data_word;
    unique case (nb)
      3'd0:    begin keep = 32'h0;        padded = {PAD_BYTE, 24'h0}; end
      3'd1:    begin keep = 32'hff000000; padded = (data_word & keep) | 32'h0080_0000; end
      3'd2:    begin keep = 32'hffff0000; padded = (data_word & keep) | 32'h0000_8000; end
      3'd3:    begin keep = 32'hffffff00; padded = (data_word & keep) | 32'h0000_0080; end
      default: begin keep = '1;           padded = data_word; end
    endcase
    msg_bytes_next = msg_bytes;
    pad_pend_next  = pad_pend;
    q_push         = 1'b0;
    q_word.kind    = KIND_DATA;
    q_word.data    = data_word;
    q_word.bit_len = {msg_bytes, 3'b000};
    if (pad_pend) begin
      if (!q_full) begin
        q_push         = 1'b1;
        q_word.kind    = KIND_FINAL;
        q_word.data    = PAD_WORD;
        pad_pend_next  = 1'b0;
        msg_bytes_next = '0;
      end
    end else if (take) begin
      q_push = 1'b1;
      if (!last_word) begin
        msg_bytes_next = msg_bytes + 61'd4;
      end else if (nb == 3'd4) begin
        msg_bytes_next = msg_bytes + 61'd4;
        pad_pend_next  = 1'b1;
      end else begin
        q_word.kind    = KIND_FINAL;
        q_word.data    = padded;
        q_word.bit_len = {msg_bytes + {58'd0, nb}, 3'b000};
        msg_bytes_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_pend  <= 1'b0;
      msg_bytes <= '0;
    end else begin
      pad_pend  <= pad_pend_next;
      msg_bytes <= msg_bytes_next;
    end
  end

endmodule

/* design/sha_queue.sv */
// ----------------------------------------------------------------------------
// sha_queue
// Short word queue between the front and the block engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha_queue #(
  parameter int DEPTH = sha_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr,
  input  sha_pkg::qword_t wdata,
  output logic            full,
  input  logic            rd,
  output sha_pkg::qword_t rdata,
  output logic            empty
);
  import sha_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  qword_t        mem [DEPTH];
  logic [AW-1:0] wp;
  logic [AW-1:0] rp;
  logic [AW:0]   cnt;

  assign full  = (cnt == (AW + 1)'(DEPTH));
  assign empty = (cnt == '0);
  assign rdata = mem[rp];

  // Store and advance pointers.
  always_ff @(posedge clk) begin
    if (wr && !full) mem[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr && !full) wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + 1'b1;
      if (rd && !empty) rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + 1'b1;
      cnt <= cnt + (AW + 1)'(wr && !full) - (AW + 1)'(rd && !empty);
    end
  end

endmodule

/* design/sha_engine.sv */
// ----------------------------------------------------------------------------
// sha_engine
// Loads block words, runs one compression round a cycle, pads and emits digest.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha_engine (
  input  logic            clk,
  input  logic            rst,
  input  sha_pkg::qword_t q_word,
  input  logic            q_empty,
  output logic            q_pop,
  output logic [31:0]     digest_word,
  output logic [2:0]      word_index,
  output logic            last_of_digest,
  output logic            empty,
  input  logic            pop
);
  import sha_pkg::*;

  `include "sha256_stream_hasher_assert.svh"

  bst_t        state;
  bst_t        state_next;
  logic [31:0] w [16];
  logic [31:0] h [8];
  logic [31:0] v [8];
  logic [3:0]  fill;
  logic [5:0]  rnd;
  logic [2:0]  oidx;
  logic        fin;
  logic        len_blk;
  logic [63:0] bit_len;
  logic        ld;
  logic [31:0] ld_data;
  logic        do_round;
  logic [31:0] s0, s1, t1, t2, wt, wnew;

  // Schedule: window of 16 words, newest at the top.
  assign wt   = w[0];
  assign s0   = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
  assign s1   = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
  assign wnew = w[0] + s0 + w[9] + s1;
  assign t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(rnd) + wt;
  assign t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));

  assign empty          = (state != ST_EMIT);
  assign digest_word    = h[oidx];
  assign word_index     = oidx;
  assign last_of_digest = (oidx == 3'd7);

  // Pick the load source and next state.
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    ld         = 1'b0;
    ld_data    = q_word.data;
    do_round   = 1'b0;
    unique case (state)
      ST_LOAD: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          ld    = 1'b1;
          if (fill == 4'd15) state_next = ST_ROUND;
          else if (q_word.kind == KIND_FINAL) state_next = ST_PAD;
        end
      end
      ST_PAD: begin
        ld = 1'b1;
        // Zero fill; the length goes only into the block that has room for it.
        if (len_blk && fill == LEN_WORD) ld_data = bit_len[63:32];
        else if (len_blk && fill == 4'd15) ld_data = bit_len[31:0];
        else ld_data = '0;
        if (fill == 4'd15) state_next = ST_ROUND;
      end
      ST_ROUND: begin
        do_round = 1'b1;
        if (rnd == 6'd63) state_next = ST_ADD;
      end
      ST_ADD: begin
        if (fin && len_blk) state_next = ST_EMIT;
        else if (fin) state_next = ST_PAD;
        else state_next = ST_LOAD;
      end
      ST_EMIT: begin
        if (pop && oidx == 3'd7) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_LOAD;
    else state <= state_next;
  end

  // Hold block words, written by index at load and shifted per round.
  always_ff @(posedge clk) begin
    if (ld) begin
      w[fill] <= ld_data;
    end else if (do_round) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
      w[15] <= wnew;
    end
  end

  // Advance counters, working variables and chain value.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      rnd     <= '0;
      oidx    <= '0;
      fin     <= 1'b0;
      len_blk <= 1'b0;
      for (int i = 0; i < 8; i++) h[i] <= init_h(3'(i));
    end else begin
      if (ld) begin
        fill <= fill + 1'b1;
        if (state == ST_LOAD && q_word.kind == KIND_FINAL) begin
          fin     <= 1'b1;
          len_blk <= (fill < LEN_WORD);
          bit_len <= q_word.bit_len;
        end
        if (fill == 4'd15) begin
          for (int i = 0; i < 8; i++) v[i] <= h[i];
          rnd <= '0;
        end
      end
      if (do_round) begin
        v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
        v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
        rnd <= rnd + 1'b1;
      end
      if (state == ST_ADD) begin
        for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
        // Final word left no room for the length: the next block carries it.
        if (fin) len_blk <= 1'b1;
      end
      if (state == ST_EMIT && pop) begin
        oidx <= oidx + 1'b1;
        if (oidx == 3'd7) begin
          fin     <= 1'b0;
          len_blk <= 1'b0;
          for (int i = 0; i < 8; i++) h[i] <= init_h(3'(i));
        end
      end
    end
  end

  `SHA_ASSERT_IMPL(a_pop_only_load, clk, rst, q_pop, state == ST_LOAD, "pop outside load")
  `SHA_ASSERT_IMPL(a_emit_fin, clk, rst, !empty, fin, "emit without final")
  `SHA_ASSERT_NEXT(a_round_end, clk, rst, state == ST_ROUND && rnd == 6'd63,
                   state == ST_ADD, "round count slip")

endmodule

/* design/sha256_stream_hasher.sv */
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 over a stream of big-endian 32-bit words.
// ----------------------------------------------------------------------------
// Input queue side: drive data_word, valid_bytes, last_word and raise push
// while full is low; a word is taken at that edge. Words other than the last
// carry four bytes. The last word carries 0..4 bytes and closes the message.
// Output queue side: while empty is low the digest word shown on digest_word
// with word_index is valid; pop takes it. Eight words per message, the eighth
// flagged by last_of_digest.
// Throughput: each 64-byte block is loaded as 16 words, then the engine
// runs 64 rounds and one add step; the one-round per cycle compression
// loop sets the rate. A short queue lets the front keep taking words while
// the engine runs rounds. Padding fills the block with zero words and the
// length, or adds a whole extra block when the tail leaves no room for the
// length. Reset returns to the initial hash value with nothing queued. A
// stalled output holds the digest word and blocks the next message's blocks
// once the queue fills.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha256_stream_hasher #(
  parameter int QDEPTH = sha_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] data_word,
  input  logic [2:0]  valid_bytes,
  input  logic        last_word,
  input  logic        push,
  output logic        full,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_of_digest,
  output logic        empty,
  input  logic        pop
);
  import sha_pkg::*;

  qword_t f_word;
  qword_t q_word;
  logic   f_push;
  logic   q_full;
  logic   q_empty;
  logic   q_pop;

  sha_front u_front (
    .clk, .rst, .data_word, .valid_bytes, .last_word, .push, .full,
    .q_word(f_word), .q_push(f_push), .q_full(q_full)
  );

  sha_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk, .rst, .wr(f_push), .wdata(f_word), .full(q_full),
    .rd(q_pop), .rdata(q_word), .empty(q_empty)
  );

  sha_engine u_engine (
    .clk, .rst, .q_word, .q_empty, .q_pop,
    .digest_word, .word_index, .last_of_digest, .empty, .pop
  );

endmodule
